>>> hw/rtl/assert_macros.svh
// Assertion macros shared by the checker files.
// Depends on nothing; include by bare file name.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Same-cycle implication, disabled while reset is high.
`define SCB_ASSERT_IMP(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("same-cycle implication failed");

// Next-cycle implication, disabled while reset is high.
`define SCB_ASSERT_NXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("next-cycle implication failed");

`endif

>>> hw/rtl/scbpg_pkg.sv
// Shared types and constants for the size-class buffer pool governor.
// Depends on nothing; imported by every RTL module of the block.
package scbpg_pkg;

   localparam int SIZE_W      = 16;
   localparam int CLASS_W     = 3;
   localparam int CSR_IDX_W   = 3;
   localparam int MAX_CLASSES = 8;
   localparam int OUT_LIMITS  = 4;
   localparam int IN_LIMITS   = 2;
   localparam int QUEUE_DEPTH = 2;

   localparam logic [SIZE_W-1:0] TOP_SIZE = 16'hFFFF;

   localparam logic OP_ALLOC = 1'b0;
   localparam logic OP_FREE  = 1'b1;
   localparam logic DIR_OUT  = 1'b0;
   localparam logic DIR_IN   = 1'b1;

   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT_0 = 3'd0;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT_1 = 3'd1;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT_2 = 3'd2;
   localparam logic [CSR_IDX_W-1:0] CSR_OUT_LIMIT_3 = 3'd3;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_LIMIT_0  = 3'd4;
   localparam logic [CSR_IDX_W-1:0] CSR_IN_LIMIT_1  = 3'd5;

   localparam logic [SIZE_W-1:0] OUT_LIMIT_0_RST = 16'd528;
   localparam logic [SIZE_W-1:0] OUT_LIMIT_1_RST = 16'd1232;
   localparam logic [SIZE_W-1:0] OUT_LIMIT_2_RST = 16'd1452;
   localparam logic [SIZE_W-1:0] OUT_LIMIT_3_RST = 16'd4096;
   localparam logic [SIZE_W-1:0] IN_LIMIT_0_RST  = 16'd576;
   localparam logic [SIZE_W-1:0] IN_LIMIT_1_RST  = 16'd1500;

   // One classified request, as it travels from front to back.
   typedef struct packed {
      logic               operation;
      logic               direction;
      logic               dropped;
      logic [CLASS_W-1:0] class_index;
      logic [SIZE_W-1:0]  class_size;
   } item_type;

endpackage

>>> hw/rtl/size_class_buffer_pool_governor_core.sv
// Size-class buffer pool governor, top level.
// A request beat passes through the queue and then the load/update/sample/shrink sequencer,
//   which takes a new request only after the previous result is registered; the sequencer
//   owns the single-ported per-class counter file.
// Reset: synchronous, active high; clears all class counters, the queue and the result
//   register at once and restores the default size limits; no clearing pass follows.
module size_class_buffer_pool_governor_core
   import scbpg_pkg::*;
#(
   parameter int OUT_CLASSES   = 5,
   parameter int IN_CLASSES    = 3,
   parameter int SAMPLE_PERIOD = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic                 req_direction,
   input  logic [SIZE_W-1:0]    req_request_size,
   output logic                 rsp_valid,
   input  logic                 rsp_stall,
   output logic [CLASS_W-1:0]   rsp_class_index,
   output logic [SIZE_W-1:0]    rsp_class_size,
   output logic                 rsp_reused,
   output logic                 rsp_refused,
   output logic                 rsp_ignored,
   output logic                 rsp_sampled,
   output logic [SIZE_W-1:0]    rsp_released,
   output logic [SIZE_W-1:0]    rsp_peak_average_now
);

   // Front to queue: classified request beats.
   logic     push_valid;
   logic     push_full;
   item_type push_item;

   // Queue to back.
   logic     pop_valid;
   logic     pop_ready;
   item_type pop_item;

   // Front: hold the limit registers, bin each request into its class and flag
   // zero-size frees. It stalls only when the queue is full.
   scbpg_front #(
      .OUT_CLASSES (OUT_CLASSES),
      .IN_CLASSES  (IN_CLASSES)
   ) u_front (
      .clock            (clock),
      .reset            (reset),
      .csr_write_enable (csr_write_enable),
      .csr_index        (csr_index),
      .csr_write_data   (csr_write_data),
      .req_valid        (req_valid),
      .req_stall        (req_stall),
      .req_operation    (req_operation),
      .req_direction    (req_direction),
      .req_request_size (req_request_size),
      .push_valid       (push_valid),
      .push_full        (push_full),
      .push_item        (push_item)
   );

   // Queue: decouple classification from the counter sequencer so that a stalled
   // result does not block request intake right away.
   scbpg_queue u_queue (
      .clock      (clock),
      .reset      (reset),
      .push_valid (push_valid),
      .push_full  (push_full),
      .push_item  (push_item),
      .pop_valid  (pop_valid),
      .pop_ready  (pop_ready),
      .pop_item   (pop_item)
   );

   // Back: read the class counters, advance them, close the sampling period when
   // due, shrink the pool, write back and present the result beat.
   scbpg_back #(
      .OUT_CLASSES   (OUT_CLASSES),
      .IN_CLASSES    (IN_CLASSES),
      .SAMPLE_PERIOD (SAMPLE_PERIOD),
      .COUNT_BITS    (COUNT_BITS)
   ) u_back (
      .clock                (clock),
      .reset                (reset),
      .queue_valid          (pop_valid),
      .queue_pop            (pop_ready),
      .queue_item           (pop_item),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_class_index      (rsp_class_index),
      .rsp_class_size       (rsp_class_size),
      .rsp_reused           (rsp_reused),
      .rsp_refused          (rsp_refused),
      .rsp_ignored          (rsp_ignored),
      .rsp_sampled          (rsp_sampled),
      .rsp_released         (rsp_released),
      .rsp_peak_average_now (rsp_peak_average_now)
   );

endmodule

>>> hw/rtl/scbpg_front.sv
// Front end: size limit registers and request classification.
// Depends on scbpg_pkg.
module scbpg_front
   import scbpg_pkg::*;
#(
   parameter int OUT_CLASSES = 5,
   parameter int IN_CLASSES  = 3
) (
   input  logic                 clock,
   input  logic                 reset,
   input  logic                 csr_write_enable,
   input  logic [CSR_IDX_W-1:0] csr_index,
   input  logic [SIZE_W-1:0]    csr_write_data,
   input  logic                 req_valid,
   output logic                 req_stall,
   input  logic                 req_operation,
   input  logic                 req_direction,
   input  logic [SIZE_W-1:0]    req_request_size,
   output logic                 push_valid,
   input  logic                 push_full,
   output item_type             push_item
);

   localparam logic [3:0] OUT_N = 4'(OUT_CLASSES);
   localparam logic [3:0] IN_N  = 4'(IN_CLASSES);

   logic [SIZE_W-1:0]  out_limit_ff [OUT_LIMITS];
   logic [SIZE_W-1:0]  in_limit_ff  [IN_LIMITS];
   logic [SIZE_W-1:0]  lim          [MAX_CLASSES];
   logic [3:0]         ncls;
   logic [CLASS_W-1:0] idx;
   logic [SIZE_W-1:0]  csize;

   always_ff @(posedge clock) begin
      if (reset) begin
         out_limit_ff[0] <= OUT_LIMIT_0_RST;
         out_limit_ff[1] <= OUT_LIMIT_1_RST;
         out_limit_ff[2] <= OUT_LIMIT_2_RST;
         out_limit_ff[3] <= OUT_LIMIT_3_RST;
         in_limit_ff[0]  <= IN_LIMIT_0_RST;
         in_limit_ff[1]  <= IN_LIMIT_1_RST;
      end else if (csr_write_enable) begin
         unique case (csr_index)
            CSR_OUT_LIMIT_0: out_limit_ff[0] <= csr_write_data;
            CSR_OUT_LIMIT_1: out_limit_ff[1] <= csr_write_data;
            CSR_OUT_LIMIT_2: out_limit_ff[2] <= csr_write_data;
            CSR_OUT_LIMIT_3: out_limit_ff[3] <= csr_write_data;
            CSR_IN_LIMIT_0:  in_limit_ff[0]  <= csr_write_data;
            CSR_IN_LIMIT_1:  in_limit_ff[1]  <= csr_write_data;
            default: ;
         endcase
      end
   end

   // Class = number of family limits the size exceeds; missing limits read as top size.
   always_comb begin
      for (int k = 0; k < MAX_CLASSES; k++) begin
         lim[k] = TOP_SIZE;
      end
      if (req_direction == DIR_OUT) begin
         for (int k = 0; k < OUT_LIMITS; k++) begin
            lim[k] = out_limit_ff[k];
         end
      end else begin
         for (int k = 0; k < IN_LIMITS; k++) begin
            lim[k] = in_limit_ff[k];
         end
      end
      ncls = (req_direction == DIR_OUT) ? OUT_N : IN_N;
      idx  = '0;
      for (int k = 0; k < MAX_CLASSES - 1; k++) begin
         if ((4'(k + 1) < ncls) && (req_request_size > lim[k])) begin
            idx = idx + 3'd1;
         end
      end
      csize = (({1'b0, idx} + 4'd1) < ncls) ? lim[idx] : TOP_SIZE;
   end

   assign req_stall  = push_full;
   assign push_valid = req_valid;

   always_comb begin
      push_item.operation   = req_operation;
      push_item.direction   = req_direction;
      push_item.dropped     = (req_operation == OP_FREE) && (req_request_size == '0);
      push_item.class_index = idx;
      push_item.class_size  = csize;
   end

endmodule

>>> hw/rtl/scbpg_queue.sv
// Short FIFO of classified requests between front and back.
// Depends on scbpg_pkg.
module scbpg_queue
   import scbpg_pkg::*;
(
   input  logic     clock,
   input  logic     reset,
   input  logic     push_valid,
   output logic     push_full,
   input  item_type push_item,
   output logic     pop_valid,
   input  logic     pop_ready,
   output item_type pop_item
);

   localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
   localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);
   localparam logic [PTR_W-1:0] LAST_PTR = PTR_W'(QUEUE_DEPTH - 1);
   localparam logic [CNT_W-1:0] FULL_CNT = CNT_W'(QUEUE_DEPTH);

   item_type         entry_ff [QUEUE_DEPTH];
   logic [PTR_W-1:0] wr_ptr_ff;
   logic [PTR_W-1:0] rd_ptr_ff;
   logic [CNT_W-1:0] count_ff;
   logic             do_push;
   logic             do_pop;

   assign push_full = (count_ff == FULL_CNT);
   assign pop_valid = (count_ff != '0);
   assign pop_item  = entry_ff[rd_ptr_ff];
   assign do_push   = push_valid && !push_full;
   assign do_pop    = pop_ready && pop_valid;

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= '0;
         rd_ptr_ff <= '0;
         count_ff  <= '0;
      end else begin
         if (do_push) begin
            entry_ff[wr_ptr_ff] <= push_item;
            wr_ptr_ff <= (wr_ptr_ff == LAST_PTR) ? '0 : wr_ptr_ff + PTR_W'(1);
         end
         if (do_pop) begin
            rd_ptr_ff <= (rd_ptr_ff == LAST_PTR) ? '0 : rd_ptr_ff + PTR_W'(1);
         end
         if (do_push && !do_pop) begin
            count_ff <= count_ff + CNT_W'(1);
         end else if (do_pop && !do_push) begin
            count_ff <= count_ff - CNT_W'(1);
         end
      end
   end

endmodule

>>> hw/rtl/scbpg_back.sv
// Back end: per-class counter file, update/sample/shrink sequencer, result register.
// Depends on scbpg_pkg.
module scbpg_back
   import scbpg_pkg::*;
#(
   parameter int OUT_CLASSES   = 5,
   parameter int IN_CLASSES    = 3,
   parameter int SAMPLE_PERIOD = 1024,
   parameter int COUNT_BITS    = 16
) (
   input  logic               clock,
   input  logic               reset,
   input  logic               queue_valid,
   output logic               queue_pop,
   input  item_type           queue_item,
   output logic               rsp_valid,
   input  logic               rsp_stall,
   output logic [CLASS_W-1:0] rsp_class_index,
   output logic [SIZE_W-1:0]  rsp_class_size,
   output logic               rsp_reused,
   output logic               rsp_refused,
   output logic               rsp_ignored,
   output logic               rsp_sampled,
   output logic [SIZE_W-1:0]  rsp_released,
   output logic [SIZE_W-1:0]  rsp_peak_average_now
);

   localparam int NUM    = OUT_CLASSES + IN_CLASSES;
   localparam int ID_W   = $clog2(NUM);
   localparam int CALL_W = $clog2(SAMPLE_PERIOD + 1);
   localparam int CB     = COUNT_BITS;
   localparam logic [CALL_W-1:0] PERIOD_C    = CALL_W'(SAMPLE_PERIOD);
   localparam logic [CB-1:0]     COUNT_MAX_C = '1;
   localparam logic [ID_W-1:0]   IN_BASE     = ID_W'(OUT_CLASSES);

   typedef enum logic [1:0] {ST_IDLE, ST_UPDATE, ST_SAMPLE, ST_SHRINK} state_type;

   state_type          state_ff;
   logic [CALL_W-1:0]  call_ff   [NUM];
   logic [CB-1:0]      in_use_ff [NUM];
   logic [CB-1:0]      owned_ff  [NUM];
   logic [CB-1:0]      peak_ff   [NUM];
   logic [CB-1:0]      avg_ff    [NUM];
   logic [CB-1:0]      spread_ff [NUM];

   item_type           item_ff;
   logic [ID_W-1:0]    id_ff;
   logic [CALL_W-1:0]  w_call_ff;
   logic [CB-1:0]      w_in_use_ff;
   logic [CB-1:0]      w_owned_ff;
   logic [CB-1:0]      w_peak_ff;
   logic [CB-1:0]      w_avg_ff;
   logic [CB-1:0]      w_spread_ff;
   logic               reused_ff;
   logic               refused_ff;
   logic               sampled_ff;

   logic               rsp_valid_ff;
   logic [CLASS_W-1:0] rsp_class_index_ff;
   logic [SIZE_W-1:0]  rsp_class_size_ff;
   logic               rsp_reused_ff;
   logic               rsp_refused_ff;
   logic               rsp_ignored_ff;
   logic               rsp_sampled_ff;
   logic [SIZE_W-1:0]  rsp_released_ff;
   logic [SIZE_W-1:0]  rsp_peak_average_now_ff;

   logic [ID_W-1:0]    id_in;
   logic               reused_in;
   logic               refused_in;
   logic               sampled_in;
   logic [CALL_W-1:0]  call_in;
   logic [CB-1:0]      in_use_in;
   logic [CB-1:0]      owned_in;
   logic [CB-1:0]      peak_in;
   logic [CB-1:0]      diff;
   logic [CB-1:0]      avg_in;
   logic [CB-1:0]      spread_in;
   logic               shrink_go;
   logic [CB-1:0]      want;
   logic [CB-1:0]      avail;
   logic [CB-1:0]      rel;
   logic [CB-1:0]      owned_final;
   logic [31:0]        rel_wide;
   logic [31:0]        avg_wide;
   logic               out_free;

   assign id_in = (queue_item.direction == DIR_IN) ? IN_BASE + ID_W'(queue_item.class_index)
                                                   : ID_W'(queue_item.class_index);
   assign queue_pop = (state_ff == ST_IDLE) && queue_valid;
   assign out_free  = !rsp_valid_ff || !rsp_stall;

   // Counter update for one call.
   always_comb begin
      reused_in  = 1'b0;
      refused_in = 1'b0;
      owned_in   = w_owned_ff;
      in_use_in  = w_in_use_ff;
      call_in    = w_call_ff;
      peak_in    = w_peak_ff;
      if (item_ff.operation == OP_ALLOC) begin
         priority if (w_owned_ff > w_in_use_ff) begin
            reused_in = 1'b1;
         end else if (w_owned_ff == COUNT_MAX_C) begin
            refused_in = 1'b1;
         end else begin
            owned_in = w_owned_ff + CB'(1);
         end
         if (!refused_in) begin
            in_use_in = w_in_use_ff + CB'(1);
            call_in   = w_call_ff + CALL_W'(1);
            if (in_use_in > w_peak_ff) begin
               peak_in = in_use_in;
            end
         end
      end else if (!item_ff.dropped) begin
         if (w_in_use_ff != '0) begin
            in_use_in = w_in_use_ff - CB'(1);
         end
         call_in = w_call_ff + CALL_W'(1);
      end
      sampled_in = !refused_in && !item_ff.dropped && (call_in >= PERIOD_C);
   end

   // Moving average (gain 1/8) and spread (gain 1/4) of the period peak.
   always_comb begin
      diff = (w_avg_ff > w_peak_ff) ? w_avg_ff - w_peak_ff : w_peak_ff - w_avg_ff;
      if (w_avg_ff != '0) begin
         avg_in    = w_avg_ff - (w_avg_ff >> 3) + (w_peak_ff >> 3);
         spread_in = w_spread_ff - (w_spread_ff >> 2) + (diff >> 2);
      end else begin
         avg_in    = w_peak_ff;
         spread_in = w_peak_ff >> 1;
      end
   end

   // On a period close with owned above 4x the average, free buffers down to half owned.
   always_comb begin
      shrink_go   = sampled_ff && ({2'b00, w_owned_ff} > {w_avg_ff, 2'b00});
      want        = w_owned_ff - (w_owned_ff >> 1);
      avail       = w_owned_ff - w_in_use_ff;
      rel         = shrink_go ? ((want < avail) ? want : avail) : '0;
      owned_final = w_owned_ff - rel;
      rel_wide    = 32'(rel);
      avg_wide    = 32'(w_avg_ff);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         rsp_valid_ff <= 1'b0;
         for (int i = 0; i < NUM; i++) begin
            call_ff[i]   <= '0;
            in_use_ff[i] <= '0;
            owned_ff[i]  <= '0;
            peak_ff[i]   <= '0;
            avg_ff[i]    <= '0;
            spread_ff[i] <= '0;
         end
      end else begin
         // Drop the result beat once taken, unless the shrink step refills it now.
         if (rsp_valid_ff && !rsp_stall && (state_ff != ST_SHRINK)) begin
            rsp_valid_ff <= 1'b0;
         end
         unique case (state_ff)
            ST_IDLE: begin
               if (queue_valid) begin
                  item_ff     <= queue_item;
                  id_ff       <= id_in;
                  w_call_ff   <= call_ff[id_in];
                  w_in_use_ff <= in_use_ff[id_in];
                  w_owned_ff  <= owned_ff[id_in];
                  w_peak_ff   <= peak_ff[id_in];
                  w_avg_ff    <= avg_ff[id_in];
                  w_spread_ff <= spread_ff[id_in];
                  state_ff    <= ST_UPDATE;
               end
            end
            ST_UPDATE: begin
               w_call_ff   <= call_in;
               w_in_use_ff <= in_use_in;
               w_owned_ff  <= owned_in;
               w_peak_ff   <= peak_in;
               reused_ff   <= reused_in;
               refused_ff  <= refused_in;
               sampled_ff  <= sampled_in;
               state_ff    <= ST_SAMPLE;
            end
            ST_SAMPLE: begin
               if (sampled_ff) begin
                  w_avg_ff    <= avg_in;
                  w_spread_ff <= spread_in;
                  w_call_ff   <= '0;
                  w_peak_ff   <= w_in_use_ff;
               end
               state_ff <= ST_SHRINK;
            end
            ST_SHRINK: begin
               if (out_free) begin
                  call_ff[id_ff]          <= w_call_ff;
                  in_use_ff[id_ff]        <= w_in_use_ff;
                  owned_ff[id_ff]         <= owned_final;
                  peak_ff[id_ff]          <= w_peak_ff;
                  avg_ff[id_ff]           <= w_avg_ff;
                  spread_ff[id_ff]        <= w_spread_ff;
                  rsp_valid_ff            <= 1'b1;
                  rsp_class_index_ff      <= item_ff.class_index;
                  rsp_class_size_ff       <= item_ff.class_size;
                  rsp_reused_ff           <= reused_ff;
                  rsp_refused_ff          <= refused_ff;
                  rsp_ignored_ff          <= item_ff.dropped;
                  rsp_sampled_ff          <= sampled_ff;
                  rsp_released_ff         <= rel_wide[SIZE_W-1:0];
                  rsp_peak_average_now_ff <= avg_wide[SIZE_W-1:0];
                  state_ff                <= ST_IDLE;
               end
            end
            default: state_ff <= ST_IDLE;
         endcase
      end
   end

   assign rsp_valid            = rsp_valid_ff;
   assign rsp_class_index      = rsp_class_index_ff;
   assign rsp_class_size       = rsp_class_size_ff;
   assign rsp_reused           = rsp_reused_ff;
   assign rsp_refused          = rsp_refused_ff;
   assign rsp_ignored          = rsp_ignored_ff;
   assign rsp_sampled          = rsp_sampled_ff;
   assign rsp_released         = rsp_released_ff;
   assign rsp_peak_average_now = rsp_peak_average_now_ff;

endmodule

>>> hw/rtl/scbpg_checker.sv
// Port-level checker for the governor core, attached by bind.
// Depends on assert_macros.svh and scbpg_pkg.
`include "assert_macros.svh"

module scbpg_checker
   import scbpg_pkg::*;
(
   input logic               clock,
   input logic               reset,
   input logic               rsp_valid,
   input logic               rsp_stall,
   input logic [CLASS_W-1:0] rsp_class_index,
   input logic [SIZE_W-1:0]  rsp_class_size,
   input logic               rsp_reused,
   input logic               rsp_refused,
   input logic               rsp_ignored,
   input logic               rsp_sampled,
   input logic [SIZE_W-1:0]  rsp_released,
   input logic [SIZE_W-1:0]  rsp_peak_average_now
);

   logic [CLASS_W+3*SIZE_W+3:0] rsp_payload;
   logic                        refused_quiet;
   logic                        ignored_quiet;

   assign rsp_payload   = {rsp_class_index, rsp_class_size, rsp_reused, rsp_refused,
                           rsp_ignored, rsp_sampled, rsp_released, rsp_peak_average_now};
   assign refused_quiet = !rsp_reused && !rsp_sampled && !rsp_ignored && (rsp_released == '0);
   assign ignored_quiet = (rsp_class_index == '0) && !rsp_reused && !rsp_refused
                          && !rsp_sampled && (rsp_released == '0);

   // A stalled result beat holds.
   `SCB_ASSERT_NXT(a_rsp_hold, clock, reset, rsp_valid && rsp_stall, rsp_valid && $stable(rsp_payload))

   // A refused allocation touches nothing.
   `SCB_ASSERT_IMP(a_refused_quiet, clock, reset, rsp_valid && rsp_refused, refused_quiet)

   // A dropped zero-size free reports class 0 and no activity.
   `SCB_ASSERT_IMP(a_ignored_quiet, clock, reset, rsp_valid && rsp_ignored, ignored_quiet)

   // Buffers are released only when a sampling period closes.
   `SCB_ASSERT_IMP(a_release_on_sample, clock, reset, rsp_valid && rsp_released != '0, rsp_sampled)

endmodule

bind size_class_buffer_pool_governor_core scbpg_checker u_checker (.*);
